@@ rtl/srts_pkg.sv @@
package srts_pkg;

    localparam int MAX_TASKS = 16;
    localparam int TIME_BITS = 16;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int ID_W      = 4;
    localparam int ID_SLOTS  = 2 ** ID_W;
    localparam int SVC_W     = 16;
    localparam int RCNT_W    = 5;

    localparam logic FUNC_ARRIVE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]  task_id;
        logic [SVC_W-1:0] left;
    } t_entry;

    // commands from the controller to the datapath
    typedef struct packed {
        logic arrive;
        logic tick_start;
        logic scan_issue;
        logic take;
        logic shift_rd;
        logic shift_wr;
        logic shift_done;
        logic append;
        logic run;
        logic out_load;
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic size_zero;
        logic busy;
        logic scan_last;
        logic shorter;
        logic shift_more;
        logic preempt;
        logic out_free;
    } t_stat;

endpackage

@@ rtl/shortest_remaining_tick_scheduler_core.sv @@
// preemptive shortest-remaining-time scheduler
// input channel (i_in_valid / o_in_ready): i_func selects a task arrival
// (i_task_id, i_service_time) or one scheduler tick. output channel
// (o_out_valid / i_out_ready) returns exactly one result per input item.
// arrivals are stamped with the current time and appended to the ready list;
// a zero service time or a full list drops the arrival
// an arrival writes the 16-entry list and goes straight to the result.
// a tick searches the list memory for the entry with least time left;
// taking a task moves each entry behind the chosen one up by a read and a
// write to close the gap, a preempted task is put back at the end of the
// list, then the task runs and the result is loaded; a tick with an empty
// list goes straight to run. the list memory has a single read port, and
// the core takes one item at a time: o_in_ready is high only between items
// reset clears the list count, the running task and the time counter;
// list contents and arrival stamps are not cleared
// a stalled receiver holds the result in the output register; the next item
// is accepted once that result is loaded, and its result waits for the
// previous one to be taken
module shortest_remaining_tick_scheduler_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_func,
    input  logic [srts_pkg::ID_W-1:0]       i_task_id,
    input  logic [srts_pkg::SVC_W-1:0]      i_service_time,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_run_valid,
    output logic [srts_pkg::ID_W-1:0]       o_run_id,
    output logic                            o_preempted,
    output logic                            o_finished,
    output logic [srts_pkg::TIME_BITS-1:0]  o_finish_time,
    output logic [srts_pkg::TIME_BITS-1:0]  o_turnaround,
    output logic [srts_pkg::RCNT_W-1:0]     o_ready_count
);
    import srts_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    srts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    srts_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_task_id      (i_task_id),
        .i_service_time (i_service_time),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_run_valid    (o_run_valid),
        .o_run_id       (o_run_id),
        .o_preempted    (o_preempted),
        .o_finished     (o_finished),
        .o_finish_time  (o_finish_time),
        .o_turnaround   (o_turnaround),
        .o_ready_count  (o_ready_count)
    );

endmodule

@@ rtl/srts_ctrl.sv @@
module srts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_func,
    output logic          o_in_ready,
    input  srts_pkg::t_stat i_stat,
    output srts_pkg::t_cmd  o_cmd
);
    import srts_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE      = 10'b00_0000_0001,
        S_SCAN      = 10'b00_0000_0010,
        S_SCAN_LAST = 10'b00_0000_0100,
        S_DECIDE    = 10'b00_0000_1000,
        S_SHIFT_RD  = 10'b00_0001_0000,
        S_SHIFT_WR  = 10'b00_0010_0000,
        S_APPEND    = 10'b00_0100_0000,
        S_RUN       = 10'b00_1000_0000,
        S_OUT       = 10'b01_0000_0000,
        S_HOLD      = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_func == FUNC_ARRIVE) begin
                        o_cmd.arrive = 1'b1;
                        n_state      = S_OUT;
                    end else begin
                        o_cmd.tick_start = 1'b1;
                        n_state          = i_stat.size_zero ? S_RUN : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_SCAN_LAST;
                end
            end
            // last compare lands at the end of this cycle
            S_SCAN_LAST: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_stat.busy && !i_stat.shorter) begin
                    n_state = S_RUN;
                end else begin
                    o_cmd.take = 1'b1;
                    n_state    = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD: begin
                if (i_stat.shift_more) begin
                    o_cmd.shift_rd = 1'b1;
                    n_state        = S_SHIFT_WR;
                end else begin
                    o_cmd.shift_done = 1'b1;
                    n_state          = i_stat.preempt ? S_APPEND : S_RUN;
                end
            end
            S_SHIFT_WR: begin
                o_cmd.shift_wr = 1'b1;
                n_state        = S_SHIFT_RD;
            end
            S_APPEND: begin
                o_cmd.append = 1'b1;
                n_state      = S_RUN;
            end
            S_RUN: begin
                o_cmd.run = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/srts_dp.sv @@
module srts_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  srts_pkg::t_cmd                  i_cmd,
    output srts_pkg::t_stat                 o_stat,
    input  logic [srts_pkg::ID_W-1:0]       i_task_id,
    input  logic [srts_pkg::SVC_W-1:0]      i_service_time,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic                            o_run_valid,
    output logic [srts_pkg::ID_W-1:0]       o_run_id,
    output logic                            o_preempted,
    output logic                            o_finished,
    output logic [srts_pkg::TIME_BITS-1:0]  o_finish_time,
    output logic [srts_pkg::TIME_BITS-1:0]  o_turnaround,
    output logic [srts_pkg::RCNT_W-1:0]     o_ready_count
);
    import srts_pkg::*;

    // ready list and arrival stamps, no reset
    t_entry               r_mem [MAX_TASKS];
    logic [TIME_BITS-1:0] r_arr [ID_SLOTS];
    t_entry               r_rd_data;
    logic [TIME_BITS-1:0] r_arr_rd;

    logic [CNT_W-1:0]     r_size;
    logic [IDX_W-1:0]     r_ptr;
    logic                 r_cmp_vld;
    logic [IDX_W-1:0]     r_cmp_idx;
    logic [IDX_W-1:0]     r_best_idx;
    t_entry               r_best;
    t_entry               r_old;
    logic                 r_busy;
    logic [ID_W-1:0]      r_active_task;
    logic [SVC_W-1:0]     r_active_left;
    logic [TIME_BITS-1:0] r_now;

    logic                 r_res_run;
    logic [ID_W-1:0]      r_res_id;
    logic                 r_res_pre;
    logic                 r_res_fin;
    logic [TIME_BITS-1:0] r_res_ftime;

    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    t_entry               wr_data;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 arr_ok;
    logic [CNT_W-1:0]     ptr_next;
    logic [SVC_W-1:0]     n_left;

    assign arr_ok   = i_cmd.arrive && (i_service_time != '0)
                      && (r_size < CNT_W'(MAX_TASKS));
    assign ptr_next = CNT_W'(r_ptr) + CNT_W'(1);
    assign n_left   = r_active_left - SVC_W'(1);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_size[IDX_W-1:0];
        wr_data = '{task_id: i_task_id, left: i_service_time};
        if (arr_ok) begin
            wr_en = 1'b1;
        end else if (i_cmd.shift_wr) begin
            wr_en   = 1'b1;
            wr_addr = r_ptr;
            wr_data = r_rd_data;
        end else if (i_cmd.append) begin
            wr_en   = 1'b1;
            wr_data = r_old;
        end
    end

    assign rd_en   = i_cmd.scan_issue || i_cmd.shift_rd;
    assign rd_addr = i_cmd.shift_rd ? ptr_next[IDX_W-1:0] : r_ptr;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (arr_ok) begin
            r_arr[i_task_id] <= r_now;
        end
        if (i_cmd.run) begin
            r_arr_rd <= r_arr[r_active_task];
        end
    end

    assign o_stat.size_zero  = (r_size == '0);
    assign o_stat.busy       = r_busy;
    assign o_stat.scan_last  = (ptr_next == r_size);
    assign o_stat.shorter    = (r_best.left < r_active_left);
    assign o_stat.shift_more = (ptr_next < r_size);
    assign o_stat.preempt    = r_res_pre;
    assign o_stat.out_free   = !o_out_valid || i_out_ready;

    // scan pointer, minimum tracking and shift pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.tick_start) begin
            r_ptr <= '0;
        end else if (i_cmd.scan_issue || i_cmd.shift_wr) begin
            r_ptr <= ptr_next[IDX_W-1:0];
        end else if (i_cmd.take) begin
            r_ptr <= r_best_idx;
        end
        r_cmp_idx <= r_ptr;
        if (r_cmp_vld && (r_cmp_idx == '0 || r_rd_data.left < r_best.left)) begin
            r_best_idx <= r_cmp_idx;
            r_best     <= r_rd_data;
        end
        if (i_cmd.take) begin
            r_old <= '{task_id: r_active_task, left: r_active_left};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld     <= 1'b0;
            r_size        <= '0;
            r_busy        <= 1'b0;
            r_active_task <= '0;
            r_active_left <= '0;
            r_now         <= '0;
            r_res_run     <= 1'b0;
            r_res_pre     <= 1'b0;
            r_res_fin     <= 1'b0;
            o_out_valid   <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan_issue;
            if (arr_ok || i_cmd.append) begin
                r_size <= r_size + CNT_W'(1);
            end else if (i_cmd.shift_done) begin
                r_size <= r_size - CNT_W'(1);
            end
            if (i_cmd.arrive || i_cmd.tick_start) begin
                r_res_run   <= 1'b0;
                r_res_id    <= '0;
                r_res_pre   <= 1'b0;
                r_res_fin   <= 1'b0;
                r_res_ftime <= '0;
            end
            if (i_cmd.take) begin
                r_res_pre     <= r_busy;
                r_busy        <= 1'b1;
                r_active_task <= r_best.task_id;
                r_active_left <= r_best.left;
            end
            if (i_cmd.run) begin
                if (r_busy) begin
                    r_res_run     <= 1'b1;
                    r_res_id      <= r_active_task;
                    r_active_left <= n_left;
                    if (n_left == '0) begin
                        r_busy      <= 1'b0;
                        r_res_fin   <= 1'b1;
                        r_res_ftime <= r_now + TIME_BITS'(1);
                    end
                end
                r_now <= r_now + TIME_BITS'(1);
            end
            if (i_cmd.out_load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_run_valid   <= r_res_run;
            o_run_id      <= r_res_id;
            o_preempted   <= r_res_pre;
            o_finished    <= r_res_fin;
            o_finish_time <= r_res_ftime;
            o_turnaround  <= r_res_fin ? (r_res_ftime - r_arr_rd) : '0;
            o_ready_count <= RCNT_W'(r_size);
        end
    end

endmodule

@@ rtl/srts_checker.sv @@
module srts_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            o_in_ready,
    input  logic                            i_func,
    input  logic [srts_pkg::ID_W-1:0]       i_task_id,
    input  logic [srts_pkg::SVC_W-1:0]      i_service_time,
    input  logic                            o_out_valid,
    input  logic                            i_out_ready,
    input  logic                            o_run_valid,
    input  logic [srts_pkg::ID_W-1:0]       o_run_id,
    input  logic                            o_preempted,
    input  logic                            o_finished,
    input  logic [srts_pkg::TIME_BITS-1:0]  o_finish_time,
    input  logic [srts_pkg::TIME_BITS-1:0]  o_turnaround,
    input  logic [srts_pkg::RCNT_W-1:0]     o_ready_count
);
    import srts_pkg::*;

    // a stalled result transaction keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_run_id)
        && $stable(o_finish_time) && $stable(o_turnaround) && $stable(o_ready_count))
        else $error("result changed while stalled");

    a_fin_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_finished || o_preempted) |-> o_run_valid)
        else $error("finish or preemption without a running task");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_finished |-> o_finish_time == '0 && o_turnaround == '0)
        else $error("finish fields set without completion");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_ready_count <= RCNT_W'(MAX_TASKS))
        else $error("ready count beyond list depth");

    // one item at a time: no new input transaction right after one is taken
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item accepted while one is in flight");

endmodule

bind shortest_remaining_tick_scheduler_core srts_checker u_srts_checker (.*);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import srts_pkg::*;

    typedef struct packed {
        logic                 run_valid;
        logic [ID_W-1:0]      run_id;
        logic                 preempted;
        logic                 finished;
        logic [TIME_BITS-1:0] finish_time;
        logic [TIME_BITS-1:0] turnaround;
        logic [RCNT_W-1:0]    ready_count;
    } t_sched_result;

    // one directed transaction; fixed_count holds the obvious ready count when fixed is set
    typedef struct packed {
        logic              func;
        logic [ID_W-1:0]   task_id;
        logic [SVC_W-1:0]  service;
        logic              fixed;
        logic [RCNT_W-1:0] fixed_count;
    } t_stim_row;

    localparam int DIRECTED_ROWS = 23;
    localparam int RANDOM_ITEMS  = 800;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_in_valid     = 1'b0;
    logic                 i_func         = FUNC_ARRIVE;
    logic [ID_W-1:0]      i_task_id      = '0;
    logic [SVC_W-1:0]     i_service_time = '0;
    logic                 i_out_ready    = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic                 o_run_valid;
    logic [ID_W-1:0]      o_run_id;
    logic                 o_preempted;
    logic                 o_finished;
    logic [TIME_BITS-1:0] o_finish_time;
    logic [TIME_BITS-1:0] o_turnaround;
    logic [RCNT_W-1:0]    o_ready_count;

    // scheduler state as predicted
    logic [ID_W-1:0]      list_id [MAX_TASKS];
    logic [SVC_W-1:0]     list_left [MAX_TASKS];
    int                   list_size;
    logic [TIME_BITS-1:0] arrival_stamp [ID_SLOTS];
    bit                   running;
    logic [ID_W-1:0]      run_task;
    logic [SVC_W-1:0]     run_left;
    logic [TIME_BITS-1:0] clock_now;

    t_sched_result expected_results [$];
    int            mismatch_count = 0;
    bit            pace_on        = 1'b1;
    int            burst_left     = 0;
    int            stall_mode     = 0;
    int            stall_span     = 0;

    t_stim_row directed_rows [DIRECTED_ROWS];

    shortest_remaining_tick_scheduler_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_task_id      (i_task_id),
        .i_service_time (i_service_time),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_run_valid    (o_run_valid),
        .o_run_id       (o_run_id),
        .o_preempted    (o_preempted),
        .o_finished     (o_finished),
        .o_finish_time  (o_finish_time),
        .o_turnaround   (o_turnaround),
        .o_ready_count  (o_ready_count)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("Mismatches found");
        $finish;
    end

    // least remaining time, oldest entry wins a tie
    function automatic int shortest_index();
        int best;
        best = 0;
        for (int i = 1; i < list_size; i++)
            if (list_left[i] < list_left[best])
                best = i;
        return best;
    endfunction

    function automatic void remove_entry(input int idx);
        run_task = list_id[idx];
        run_left = list_left[idx];
        for (int i = idx; i + 1 < list_size; i++) begin
            list_id[i]   = list_id[i + 1];
            list_left[i] = list_left[i + 1];
        end
        list_size--;
    endfunction

    function automatic t_sched_result schedule_item(input logic func, input logic [ID_W-1:0] id,
                                                    input logic [SVC_W-1:0] svc);
        t_sched_result    r;
        logic [ID_W-1:0]  old_task;
        logic [SVC_W-1:0] old_left;
        bit               shorter;
        r = '0;
        if (func == FUNC_ARRIVE) begin
            if (svc != 0 && list_size < MAX_TASKS) begin
                list_id[list_size]   = id;
                list_left[list_size] = svc;
                arrival_stamp[id]    = clock_now;
                list_size++;
            end
        end else begin
            if (running && list_size > 0) begin
                shorter = 1'b0;
                for (int i = 0; i < list_size; i++)
                    if (list_left[i] < run_left)
                        shorter = 1'b1;
                if (shorter) begin
                    old_task = run_task;
                    old_left = run_left;
                    // chosen entry leaves first, so a full list has room for the put-back
                    remove_entry(shortest_index());
                    list_id[list_size]   = old_task;
                    list_left[list_size] = old_left;
                    list_size++;
                    r.preempted = 1'b1;
                end
            end
            if (!running && list_size > 0) begin
                remove_entry(shortest_index());
                running = 1'b1;
            end
            if (running) begin
                r.run_valid = 1'b1;
                r.run_id    = run_task;
                run_left    = run_left - 1'b1;
                if (run_left == 0) begin
                    running       = 1'b0;
                    r.finished    = 1'b1;
                    r.finish_time = clock_now + 1'b1;
                    r.turnaround  = clock_now + 1'b1 - arrival_stamp[run_task];
                end
            end
            clock_now = clock_now + 1'b1;
        end
        r.ready_count = RCNT_W'(list_size);
        return r;
    endfunction

    task automatic send_item(input logic func, input logic [ID_W-1:0] id,
                             input logic [SVC_W-1:0] svc, input logic fixed,
                             input logic [RCNT_W-1:0] fixed_count);
        t_sched_result r;
        int            gap;
        @(negedge i_clk);
        if (pace_on) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(0, 8);
                burst_left = $urandom_range(1, 24);
                if (gap > 0) begin
                    i_in_valid = 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            burst_left--;
        end
        i_in_valid     = 1'b1;
        i_func         = func;
        i_task_id      = id;
        i_service_time = svc;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        r = schedule_item(func, id, svc);
        if (fixed) begin
            r             = '0;
            r.ready_count = fixed_count;
        end
        expected_results.insert(expected_results.size(), r);
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_sched_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transaction with nothing expected");
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("run_valid", want.run_valid, o_run_valid);
                check_field("run_id", want.run_id, o_run_id);
                check_field("preempted", want.preempted, o_preempted);
                check_field("finished", want.finished, o_finished);
                check_field("finish_time", want.finish_time, o_finish_time);
                check_field("turnaround", want.turnaround, o_turnaround);
                check_field("ready_count", want.ready_count, o_ready_count);
            end
        end
    end

    // receiver back-pressure: the mode is redrawn whenever its random span runs out
    always @(negedge i_clk) begin
        if (!pace_on) begin
            i_out_ready = 1'b1;
        end else begin
            if (stall_span == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_span = $urandom_range(20, 200);
            end
            stall_span--;
            case (stall_mode)
                0: begin
                    i_out_ready = 1'b1;
                end
                1: begin
                    i_out_ready = 1'($urandom_range(0, 1));
                end
                2: begin
                    i_out_ready = ($urandom_range(0, 3) == 0);
                end
                default: begin
                    i_out_ready = (stall_span % 16) < 10;
                end
            endcase
        end
    end

    initial begin : stimulus
        int               counted;
        int               seg_len;
        int               arrive_pct;
        int               roll;
        logic             func;
        logic [ID_W-1:0]  id;
        logic [SVC_W-1:0] svc;

        list_size = 0;
        running   = 1'b0;
        run_task  = '0;
        run_left  = '0;
        clock_now = '0;

        directed_rows = '{
            '{FUNC_TICK,   4'd0,  16'd0,   1'b1, 5'd0},   // idle tick after reset
            '{FUNC_ARRIVE, 4'd5,  16'd0,   1'b1, 5'd0},   // zero service dropped
            '{FUNC_ARRIVE, 4'd15, 16'd3,   1'b1, 5'd1},
            '{FUNC_ARRIVE, 4'd3,  16'd9,   1'b0, 5'd0},
            '{FUNC_TICK,   4'd0,  16'd0,   1'b0, 5'd0},
            '{FUNC_ARRIVE, 4'd0,  16'd40,  1'b0, 5'd0},
            '{FUNC_ARRIVE, 4'd1,  16'd7,   1'b0, 5'd0},
            '{FUNC_ARRIVE, 4'd2,  16'd12,  1'b0, 5'd0},
            '{FUNC_ARRIVE, 4'd4,  16'd255, 1'b0, 5'd0},
            '{FUNC_ARRIVE, 4'd5,  16'd6,   1'b0, 5'd0},
            '{FUNC_ARRIVE, 4'd6,  16'd30,  1'b0, 5'd0},
            '{FUNC_ARRIVE, 4'd7,  16'd11,  1'b0, 5'd0},
            '{FUNC_ARRIVE, 4'd8,  16'd2,   1'b0, 5'd0},
            '{FUNC_ARRIVE, 4'd3,  16'd17,  1'b0, 5'd0},   // id 3 again, newer stamp
            '{FUNC_ARRIVE, 4'd10, 16'd5,   1'b0, 5'd0},
            '{FUNC_ARRIVE, 4'd11, 16'd21,  1'b0, 5'd0},
            '{FUNC_ARRIVE, 4'd12, 16'd4,   1'b0, 5'd0},
            '{FUNC_ARRIVE, 4'd13, 16'd13,  1'b0, 5'd0},
            '{FUNC_ARRIVE, 4'd14, 16'd8,   1'b0, 5'd0},
            '{FUNC_ARRIVE, 4'd9,  16'd1,   1'b0, 5'd0},   // list now full
            '{FUNC_ARRIVE, 4'd6,  16'd5,   1'b1, 5'd16},  // dropped, list full
            '{FUNC_TICK,   4'd0,  16'd0,   1'b0, 5'd0},   // preempt with a full list
            '{FUNC_TICK,   4'd0,  16'd0,   1'b0, 5'd0}
        };

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[k])
            send_item(directed_rows[k].func, directed_rows[k].task_id, directed_rows[k].service,
                      directed_rows[k].fixed, directed_rows[k].fixed_count);

        // each random segment draws an arrival share of 10, 35 or 80 percent, so the list fills or drains
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            seg_len = $urandom_range(10, 60);
            roll    = $urandom_range(0, 2);
            arrive_pct = (roll == 0) ? 10 : (roll == 1) ? 35 : 80;
            repeat (seg_len) begin
                func = ($urandom_range(0, 99) < arrive_pct) ? FUNC_ARRIVE : FUNC_TICK;
                id   = ID_W'($urandom_range(0, 15));
                roll = $urandom_range(0, 99);
                if (roll < 2)
                    svc = SVC_W'($urandom_range(0, 65535));
                else if (roll < 7)
                    svc = '0;
                else if (roll < 15)
                    svc = SVC_W'($urandom_range(1, 12));
                else
                    svc = SVC_W'($urandom_range(1, 4));
                if (func == FUNC_TICK)
                    svc = SVC_W'($urandom_range(0, 65535));
                send_item(func, id, svc, 1'b0, '0);
                counted++;
            end
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/srts_pkg.sv
rtl/srts_ctrl.sv
rtl/srts_dp.sv
rtl/shortest_remaining_tick_scheduler_core.sv
rtl/srts_checker.sv
verif/testbench.sv
